/* hdl/kv_head_expansion_gather_top_defines.svh */
// ----------------------------------------------------------------------------
// KV head expansion gather: assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KV_HEAD_EXPANSION_GATHER_TOP_DEFINES_SVH
`define KV_HEAD_EXPANSION_GATHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KHEG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kheg same-cycle check failed");

// next-cycle implication
`define KHEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kheg next-cycle check failed");

`else

`define KHEG_ASSERT_IMP(label, clk, rst, ante, cons)
`define KHEG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/kheg_pkg.sv */
// ----------------------------------------------------------------------------
// kheg_pkg
// Shared widths, codes and beat types of the KV head expansion gather block.
// ----------------------------------------------------------------------------
`default_nettype none

package kheg_pkg;

   // sizes
   localparam int MAX_SOURCE_WIDTH = 1024;
   localparam int MAX_TARGET_WIDTH = 4096;
   localparam int ADDR_W      = $clog2(MAX_SOURCE_WIDTH);
   localparam int COL_W       = 12;
   localparam int ELEM_W      = 32;
   localparam int SW_W        = 11;
   localparam int TW_W        = 13;
   localparam int HEAD_W      = 9;
   localparam int DIV_W       = 13;
   localparam int PROD_W      = DIV_W + HEAD_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_HEADS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KV_HEADS     = 2'd3;

   typedef struct packed {
      logic              command;
      logic [COL_W-1:0]  column;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element_out;
      logic [ADDR_W-1:0] source_column;
      logic              head_mapped;
      logic              column_error;
   } rsp_type;

   // one classified operation for the back end
   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] element;
      logic              head_mapped;
      logic              column_error;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type entry;
   } q_push_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

/* hdl/kheg_div.sv */
// ----------------------------------------------------------------------------
// kheg_div
// Restoring divider, one quotient bit per cycle, DIV_W steps per division.
// ----------------------------------------------------------------------------
`default_nettype none

module kheg_div
   import kheg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;

   logic [DIV_W:0]   partial;
   logic [DIV_W:0]   diff;
   logic             ge;

   // one shift-subtract step
   always_comb begin
      partial = {rem_ff, quo_ff[DIV_W-1]};
      diff    = partial - {1'b0, dvs_ff};
      ge      = (partial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

/* hdl/kheg_front.sv */
// ----------------------------------------------------------------------------
// kheg_front
// Holds the configuration, accepts request beats and finds each fetch's source
// column with a shared divider; pushes one entry per operation but dropped loads.
// ----------------------------------------------------------------------------
`default_nettype none

module kheg_front
   import kheg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  q_full,
   output q_push_type                 q_push
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLASS = 4'd1;
   localparam logic [3:0] S_D1    = 4'd2;
   localparam logic [3:0] S_D2    = 4'd3;
   localparam logic [3:0] S_MUL1  = 4'd4;
   localparam logic [3:0] S_OK    = 4'd5;
   localparam logic [3:0] S_MAP   = 4'd6;
   localparam logic [3:0] S_D3    = 4'd7;
   localparam logic [3:0] S_D4    = 4'd8;
   localparam logic [3:0] S_MUL2  = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_D5    = 4'd11;
   localparam logic [3:0] S_PUSH  = 4'd12;

   // configuration
   logic [SW_W-1:0]   src_width_ff;
   logic [TW_W-1:0]   tgt_width_ff;
   logic [HEAD_W-1:0] q_heads_ff;
   logic [HEAD_W-1:0] kv_heads_ff;

   // control and working registers
   logic [3:0]        state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [DIV_W-1:0]  hd_ff, hd_in;
   logic [DIV_W-1:0]  grp_ff, grp_in;
   logic              r1z_ff, r1z_in;
   logic              r2z_ff, r2z_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              ok_ff, ok_in;
   logic              cfg_known_ff, cfg_known_in;
   logic [DIV_W-1:0]  off_ff, off_in;
   logic [HEAD_W-1:0] kvh_ff, kvh_in;
   logic [ADDR_W-1:0] pk_addr_ff, pk_addr_in;
   logic              pk_mapped_ff, pk_mapped_in;
   logic              pk_err_ff, pk_err_in;

   logic [SW_W-1:0]   sw_eff;
   logic [TW_W-1:0]   tw_eff;
   logic [HEAD_W-1:0] qh_eff;
   logic [HEAD_W-1:0] kh_eff;
   logic [HEAD_W-1:0] kh_m1;
   logic [PROD_W-1:0] sum;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // effective widths and head counts
   always_comb begin
      if (src_width_ff == '0) begin
         sw_eff = SW_W'(1);
      end else if (src_width_ff > SW_W'(MAX_SOURCE_WIDTH)) begin
         sw_eff = SW_W'(MAX_SOURCE_WIDTH);
      end else begin
         sw_eff = src_width_ff;
      end
      tw_eff = (tgt_width_ff > TW_W'(MAX_TARGET_WIDTH)) ? TW_W'(MAX_TARGET_WIDTH)
                                                        : tgt_width_ff;
      qh_eff = (q_heads_ff == '0) ? HEAD_W'(1) : q_heads_ff;
      kh_eff = (kv_heads_ff == '0) ? HEAD_W'(1) : kv_heads_ff;
      kh_m1  = kh_eff - 1'b1;
      sum    = prod_ff + PROD_W'(off_ff);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      elem_in      = elem_ff;
      hd_in        = hd_ff;
      grp_in       = grp_ff;
      r1z_in       = r1z_ff;
      r2z_in       = r2z_ff;
      prod_in      = prod_ff;
      ok_in        = ok_ff;
      cfg_known_in = cfg_known_ff;
      off_in       = off_ff;
      kvh_in       = kvh_ff;
      pk_addr_in   = pk_addr_ff;
      pk_mapped_in = pk_mapped_ff;
      pk_err_in    = pk_err_ff;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               col_in   = req_data.column;
               elem_in  = req_data.element;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            pk_mapped_in = 1'b0;
            pk_err_in    = 1'b0;
            pk_addr_in   = col_ff[ADDR_W-1:0];
            if (cmd_ff == CMD_LOAD) begin
               state_in = (col_ff < COL_W'(sw_eff)) ? S_PUSH : S_IDLE;
            end else if ({1'b0, col_ff} >= tw_eff) begin
               pk_err_in  = 1'b1;
               pk_addr_in = '0;
               state_in   = S_PUSH;
            end else if (TW_W'(sw_eff) == tw_eff) begin
               state_in = S_PUSH;
            end else if (cfg_known_ff) begin
               state_in = S_MAP;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(tw_eff);
               div_req.divisor  = DIV_W'(qh_eff);
               state_in         = S_D1;
            end
         end
         // head width = target / query heads
         S_D1: begin
            if (div_rsp.done) begin
               hd_in            = div_rsp.quotient;
               r1z_in           = (div_rsp.remainder == '0);
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(qh_eff);
               div_req.divisor  = DIV_W'(kh_eff);
               state_in         = S_D2;
            end
         end
         // group size = query heads / kv heads
         S_D2: begin
            if (div_rsp.done) begin
               grp_in   = div_rsp.quotient;
               r2z_in   = (div_rsp.remainder == '0);
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            prod_in  = PROD_W'(hd_ff) * PROD_W'(kh_eff);
            state_in = S_OK;
         end
         S_OK: begin
            ok_in        = r1z_ff && r2z_ff && (hd_ff != '0) && (prod_ff == PROD_W'(sw_eff));
            cfg_known_in = 1'b1;
            state_in     = S_MAP;
         end
         S_MAP: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(col_ff);
            if (ok_ff) begin
               div_req.divisor = hd_ff;
               state_in        = S_D3;
            end else begin
               div_req.divisor = DIV_W'(sw_eff);
               state_in        = S_D5;
            end
         end
         // query head and offset inside the head
         S_D3: begin
            if (div_rsp.done) begin
               off_in           = div_rsp.remainder;
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = grp_ff;
               state_in         = S_D4;
            end
         end
         // kv head, clamped to the last one
         S_D4: begin
            if (div_rsp.done) begin
               kvh_in   = (div_rsp.quotient > DIV_W'(kh_m1)) ? kh_m1
                                                             : div_rsp.quotient[HEAD_W-1:0];
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            prod_in  = PROD_W'(kvh_ff) * PROD_W'(hd_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            pk_addr_in   = (sum < PROD_W'(MAX_SOURCE_WIDTH)) ? sum[ADDR_W-1:0] : '0;
            pk_mapped_in = 1'b1;
            state_in     = S_PUSH;
         end
         // plain modulo by the source width
         S_D5: begin
            if (div_rsp.done) begin
               pk_addr_in = div_rsp.remainder[ADDR_W-1:0];
               state_in   = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // new configuration invalidates the cached head mapping
      if (csr_valid) begin
         cfg_known_in = 1'b0;
      end
   end

   assign q_push.valid              = (state_ff == S_PUSH) && !q_full;
   assign q_push.entry.command      = cmd_ff;
   assign q_push.entry.addr         = pk_addr_ff;
   assign q_push.entry.element      = elem_ff;
   assign q_push.entry.head_mapped  = pk_mapped_ff;
   assign q_push.entry.column_error = pk_err_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff <= SW_W'(1);
         tgt_width_ff <= TW_W'(1);
         q_heads_ff   <= HEAD_W'(1);
         kv_heads_ff  <= HEAD_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH: src_width_ff <= csr_data[SW_W-1:0];
            CSR_TARGET_WIDTH: tgt_width_ff <= csr_data[TW_W-1:0];
            CSR_QUERY_HEADS:  q_heads_ff   <= csr_data[HEAD_W-1:0];
            CSR_KV_HEADS:     kv_heads_ff  <= csr_data[HEAD_W-1:0];
            default:          src_width_ff <= src_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_known_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_known_ff <= cfg_known_in;
      end
      cmd_ff       <= cmd_in;
      col_ff       <= col_in;
      elem_ff      <= elem_in;
      hd_ff        <= hd_in;
      grp_ff       <= grp_in;
      r1z_ff       <= r1z_in;
      r2z_ff       <= r2z_in;
      prod_ff      <= prod_in;
      ok_ff        <= ok_in;
      off_ff       <= off_in;
      kvh_ff       <= kvh_in;
      pk_addr_ff   <= pk_addr_in;
      pk_mapped_ff <= pk_mapped_in;
      pk_err_ff    <= pk_err_in;
   end

   kheg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

`default_nettype wire

/* hdl/kheg_queue.sv */
// ----------------------------------------------------------------------------
// kheg_queue
// Small FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kv_head_expansion_gather_top_defines.svh"

module kheg_queue
   import kheg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_push_type q_push,
   output logic            q_full,
   input  wire logic       pop,
   output logic            q_valid,
   output qent_type        q_head
);

   qent_type          ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign q_full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_head  = ent_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         ent_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (q_push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (q_push.valid && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !q_push.valid) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   `KHEG_ASSERT_IMP(a_no_push_full, clock, reset, q_push.valid, !q_full)
   `KHEG_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, q_valid)

endmodule

`default_nettype wire

/* hdl/kheg_back.sv */
// ----------------------------------------------------------------------------
// kheg_back
// Row buffer and response stage: writes loads, reads fetches and holds the
// response beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kv_head_expansion_gather_top_defines.svh"

module kheg_back
   import kheg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire qent_type q_head,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic [ELEM_W-1:0] row_mem [MAX_SOURCE_WIDTH];

   logic              rd_pend_ff;
   logic [ELEM_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              rd_mapped_ff;
   logic              rd_err_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              is_fetch;

   // loads retire at once; a fetch waits for a free response slot
   assign is_fetch = (q_head.command == CMD_FETCH);
   assign pop      = q_valid && (!is_fetch || (!rd_pend_ff && !rsp_valid_ff));

   // row buffer
   always_ff @(posedge clock) begin
      if (pop && !is_fetch) begin
         row_mem[q_head.addr] <= q_head.element;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_fetch) begin
         rd_data_ff <= row_mem[q_head.addr];
      end
   end

   // read side info
   always_ff @(posedge clock) begin
      if (pop && is_fetch) begin
         rd_addr_ff   <= q_head.addr;
         rd_mapped_ff <= q_head.head_mapped;
         rd_err_ff    <= q_head.column_error;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= pop && is_fetch;
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rd_pend_ff) begin
         rsp_data_ff.element_out   <= rd_err_ff ? '0 : rd_data_ff;
         rsp_data_ff.source_column <= rd_addr_ff;
         rsp_data_ff.head_mapped   <= rd_mapped_ff;
         rsp_data_ff.column_error  <= rd_err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KHEG_ASSERT_NEXT(a_read_to_rsp, clock, reset, rd_pend_ff, rsp_valid_ff)
   `KHEG_ASSERT_IMP(a_one_in_flight, clock, reset, rsp_valid_ff, !rd_pend_ff)

endmodule

`default_nettype wire

/* hdl/kv_head_expansion_gather_top.sv */
// ----------------------------------------------------------------------------
// kv_head_expansion_gather_top
// Widens a key/value row to the query width: loads fill a row buffer, fetches
// return the source element mapped to an output column.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  req_    | in        | req_type: command, column, element
//  rsp_    | out       | rsp_type: element_out, source_column, head_mapped,
//          |           |           column_error (one beat per fetch)
//  csr_    | in        | index 0..3, 13-bit data, always ready
//
//  One request at a time in the front end. A load, an out-of-range fetch or
//  an equal-width fetch needs no division; a modulo fetch takes one and a
//  head-mapped fetch two, on the 13-step divider (one bit a cycle). The first
//  mapped or modulo fetch after a register write also derives the head
//  mapping. A full 4-entry queue stalls the front; a fetch waits for the
//  response slot. Synchronous reset; row buffer not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_head_expansion_gather_top
   import kheg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   q_push_type q_push;
   logic       q_full;
   logic       q_valid;
   qent_type   q_head;
   logic       pop;

   kheg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   kheg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .pop     (pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   kheg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
